// ===== src/ahs_pkg.sv =====
package ahs_pkg;

    // Fixed field widths
    localparam int GAIN_W    = 17;   // filter gain, Q1.16 unsigned
    localparam int OFFS_W    = 12;   // fixed hysteresis offset
    localparam int MID_W     = 14;   // midpoint, two's complement
    localparam int HYS_W     = 18;   // adaptive hysteresis, unsigned
    localparam int FRAC_W    = 16;   // fraction bits of the gain
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam int ROUND_HALF = 32'h0000_8000;
    localparam int MID_MIN    = -(2 ** (MID_W - 1));
    localparam int MID_MAX    = (2 ** (MID_W - 1)) - 1;

    // adaptive hysteresis: decay by hys/16, update gated by hys/32
    localparam int HYS_DECAY_SHIFT = 4;
    localparam int HYS_GATE_SHIFT  = 5;

    // result beat: level_now, midpoint_out, adaptive_hys_out
    localparam int OUT_FIELDS_W = 1 + MID_W + HYS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_GAIN = 2'd0,
        REG_HYS_OFFSET  = 2'd1,
        REG_USE_VOLTAGE = 2'd2,
        REG_ACC_ENABLE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] filter_gain;
        logic [OFFS_W-1:0] hysteresis_offset;
        logic              use_voltage;
        logic              accumulate_enable;
    } cfg_t;

endpackage

// ===== src/ahs_cfg_regs.sv =====
module ahs_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ahs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ahs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output ahs_pkg::cfg_t                  cfg
);
    import ahs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FILTER_GAIN: cfg_next.filter_gain       = cfg_wdata[GAIN_W-1:0];
                REG_HYS_OFFSET:  cfg_next.hysteresis_offset = cfg_wdata[OFFS_W-1:0];
                REG_USE_VOLTAGE: cfg_next.use_voltage       = cfg_wdata[0];
                REG_ACC_ENABLE:  cfg_next.accumulate_enable = cfg_wdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_gain       <= '0;
            cfg_reg.hysteresis_offset <= '0;
            cfg_reg.use_voltage       <= 1'b1;
            cfg_reg.accumulate_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/ahs_datapath.sv =====
module ahs_datapath
#(
    parameter int ADC_BITS = 12
)
(
    input  ahs_pkg::cfg_t                     cfg,
    input  logic [ADC_BITS-1:0]               voltage_sample,
    input  logic [ADC_BITS-1:0]               current_sample,
    input  logic                              level_before,
    input  logic signed [ahs_pkg::MID_W-1:0]  midpoint,
    input  logic [ahs_pkg::HYS_W-1:0]         adaptive_hys,
    output logic                              level_now,
    output logic signed [ahs_pkg::MID_W-1:0]  midpoint_new,
    output logic [ahs_pkg::HYS_W-1:0]         adaptive_hys_new
);
    import ahs_pkg::*;

    // x - mid spans roughly -2^(MID_W-1) .. 2^ADC_BITS + 2^(MID_W-1)
    localparam int SPAN_W = (ADC_BITS > MID_W - 1) ? ADC_BITS : MID_W - 1;
    localparam int DIFF_W = SPAN_W + 2;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int STEP_W = PROD_W - FRAC_W;
    localparam int NM_W   = STEP_W + 1;
    localparam int CMP_W  = DIFF_W + 1;
    localparam int ABS_W  = DIFF_W - 1;
    localparam int HACC_W = HYS_W + 2;

    logic [ADC_BITS-1:0]      raw;
    logic signed [DIFF_W-1:0] x_s;
    logic signed [DIFF_W-1:0] mid_s;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] diff_ext;
    logic signed [PROD_W-1:0] gain_ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [STEP_W-1:0] step;
    logic signed [NM_W-1:0]   nm_wide;
    logic signed [CMP_W-1:0]  mid_cmp;
    logic signed [CMP_W-1:0]  offs_cmp;
    logic signed [CMP_W-1:0]  thr;
    logic signed [CMP_W-1:0]  x_cmp;
    logic signed [DIFF_W-1:0] mid_new_s;
    logic signed [DIFF_W-1:0] dev;
    logic signed [DIFF_W-1:0] dev_neg;
    logic [ABS_W-1:0]         dev_abs;
    logic [HACC_W-1:0]        dev_ext;
    logic [HACC_W-1:0]        hys_ext;
    logic [HACC_W-1:0]        hys_sum;
    logic                     hys_gate;

    // low-pass step: floor((diff * gain + half) / 2^16)
    assign raw      = cfg.use_voltage ? voltage_sample : current_sample;
    assign x_s      = signed'({{(DIFF_W-ADC_BITS){1'b0}}, raw});
    assign mid_s    = {{(DIFF_W-MID_W){midpoint[MID_W-1]}}, midpoint};
    assign diff     = x_s - mid_s;
    assign diff_ext = {{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff};
    assign gain_ext = signed'({{(PROD_W-GAIN_W){1'b0}}, cfg.filter_gain});
    assign prod     = diff_ext * gain_ext;
    assign prod_rnd = prod + PROD_W'(ROUND_HALF);
    assign step     = prod_rnd[PROD_W-1:FRAC_W];
    assign nm_wide  = {{(NM_W-MID_W){midpoint[MID_W-1]}}, midpoint}
                    + {step[STEP_W-1], step};

    always_comb
    begin
        if (nm_wide < NM_W'(MID_MIN))
            midpoint_new = MID_W'(MID_MIN);
        else if (nm_wide > NM_W'(MID_MAX))
            midpoint_new = MID_W'(MID_MAX);
        else
            midpoint_new = nm_wide[MID_W-1:0];
    end

    // threshold moves up after a low level, down after a high level
    assign mid_cmp  = {{(CMP_W-MID_W){midpoint_new[MID_W-1]}}, midpoint_new};
    assign offs_cmp = signed'({{(CMP_W-OFFS_W){1'b0}}, cfg.hysteresis_offset});
    assign thr      = level_before ? (mid_cmp - offs_cmp) : (mid_cmp + offs_cmp);
    assign x_cmp    = {x_s[DIFF_W-1], x_s};
    assign level_now = !(x_cmp < thr);

    // adaptive hysteresis
    assign mid_new_s = {{(DIFF_W-MID_W){midpoint_new[MID_W-1]}}, midpoint_new};
    assign dev       = mid_new_s - x_s;
    assign dev_neg   = -dev;
    assign dev_abs   = dev[DIFF_W-1] ? dev_neg[ABS_W-1:0] : dev[ABS_W-1:0];
    assign dev_ext   = HACC_W'(dev_abs);
    assign hys_ext   = HACC_W'(adaptive_hys);
    assign hys_gate  = dev_ext > (hys_ext >> HYS_GATE_SHIFT);
    assign hys_sum   = hys_ext + dev_ext - (hys_ext >> HYS_DECAY_SHIFT);

    always_comb
    begin
        if (!(cfg.accumulate_enable && hys_gate))
            adaptive_hys_new = adaptive_hys;
        else if (hys_sum[HACC_W-1:HYS_W] != '0)
            adaptive_hys_new = '1;
        else
            adaptive_hys_new = hys_sum[HYS_W-1:0];
    end

endmodule

// ===== src/adaptive_hysteresis_slicer.sv =====
// Adaptive hysteresis slicer. Each input beat carries a voltage and a current
// ADC count plus the previously decided logic level. The block picks one
// sample (use_voltage), moves a tracked midpoint toward it with a low-pass
// step with a Q1.16 gain, mid += floor(((x - mid) * filter_gain + 0x8000) / 2^16),
// saturated to 14 bits, and slices the sample against mid + hysteresis_offset
// (previous level low) or mid - hysteresis_offset (previous level high):
// level_now is 1 when the sample is at or above that threshold. With
// accumulate_enable set, an 18-bit adaptive hysteresis grows by
// |mid - x| - hys/16 whenever |mid - x| > hys/32, saturating at its maximum.
// One result beat per input beat, in order, via the input register and then
// the result register. Throughput is one beat per cycle unless m_tready
// holds a result back: the midpoint and hysteresis update (one 15x17
// multiply, an add and the compares) is combinational between the input
// register and the state/result registers. While a result waits, the input
// register takes one more beat, then drops s_tready until the result drains.
// Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect on the next
// clock and must only be made while the block is idle.
module adaptive_hysteresis_slicer
#(
    parameter int ADC_BITS = 12
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [ahs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ahs_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // voltage_sample, current_sample, level_before; zero padded to bytes
    input  logic [((2*ADC_BITS+8)/8)*8-1:0]       s_tdata,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // level_now, midpoint_out, adaptive_hys_out; zero padded to bytes
    output logic [ahs_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import ahs_pkg::*;

    localparam int LVL_BIT = 2 * ADC_BITS;

    cfg_t cfg;

    // input stage
    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic [ADC_BITS-1:0]        volt_reg;
    logic [ADC_BITS-1:0]        curr_reg;
    logic                       lvl_before_reg;

    // result stage; midpoint and hysteresis double as the filter state
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       level_reg;
    logic signed [MID_W-1:0]    midpoint_reg;
    logic [HYS_W-1:0]           hys_reg;

    logic                       level_calc;
    logic signed [MID_W-1:0]    midpoint_calc;
    logic [HYS_W-1:0]           hys_calc;

    logic                       in_beat;
    logic                       out_free;
    logic                       load;

    ahs_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ahs_datapath #(.ADC_BITS(ADC_BITS)) u_dp
    (
        .cfg              (cfg),
        .voltage_sample   (volt_reg),
        .current_sample   (curr_reg),
        .level_before     (lvl_before_reg),
        .midpoint         (midpoint_reg),
        .adaptive_hys     (hys_reg),
        .level_now        (level_calc),
        .midpoint_new     (midpoint_calc),
        .adaptive_hys_new (hys_calc)
    );

    // Result slot is free when empty or being drained this cycle. The input
    // register only stalls when the result slot is full and held.
    assign out_free = !out_valid_reg || m_tready;
    assign load     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_beat  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_beat)
            in_valid_next = 1'b1;
        else if (load)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            midpoint_reg  <= '0;
            hys_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                midpoint_reg <= midpoint_calc;
                hys_reg      <= hys_calc;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            volt_reg       <= s_tdata[ADC_BITS-1:0];
            curr_reg       <= s_tdata[2*ADC_BITS-1:ADC_BITS];
            lvl_before_reg <= s_tdata[LVL_BIT];
        end
        if (load)
            level_reg <= level_calc;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({hys_reg, midpoint_reg, level_reg});

endmodule

// ===== src/ahs_checker.sv =====
module ahs_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ahs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ahs_pkg::*;

    // a held result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input side only backs off when a result is held downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without downstream back-pressure");

    // an empty result slot fills only from a beat that went through the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result beat with no matching input beat");

endmodule

bind adaptive_hysteresis_slicer ahs_checker u_ahs_checker (.*);

// ===== test/tb_adaptive_hysteresis_slicer.sv =====
module tb_adaptive_hysteresis_slicer;
    timeunit 1ns;
    timeprecision 1ps;

    import ahs_pkg::*;

    localparam int ADC_W       = 12;
    localparam int ADC_MAX     = (1 << ADC_W) - 1;
    localparam int IN_TDATA_W  = ((2 * ADC_W + 8) / 8) * 8;
    localparam int GAIN_ONE    = 1 << FRAC_W;
    localparam int GAIN_TOP    = (1 << GAIN_W) - 1;
    localparam int OFFS_TOP    = (1 << OFFS_W) - 1;
    localparam longint HYS_TOP = (longint'(1) << HYS_W) - 1;

    localparam int IDLE_PCT    = 23;    // chance of a gap, per cycle, on either side
    localparam int HOLD_CYCLES = 120;   // long back-pressure burst, fills the pipe
    localparam int STALL_LIMIT = 3000;  // cycles with no beat on either side
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 210;

    // one result beat, as the slicer should produce it
    typedef struct packed {
        logic             level_now;
        logic [MID_W-1:0] midpoint;
        logic [HYS_W-1:0] adaptive_hys;
    } slice_t;

    // directed row: register settings, input beat, and a hand-worked result
    // where one is obvious (typed set); otherwise the tracker decides
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [OFFS_W-1:0] offs;
        logic              use_v;
        logic              acc_en;
        logic [ADC_W-1:0]  volt;
        logic [ADC_W-1:0]  curr;
        logic              lvl_before;
        logic              typed;
        slice_t            res;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [0:23] = '{
        // gain    offs  uv acc  volt  curr lb typ  result
        // fresh from reset: everything zero, equality slices high
        '{0,      0,    1, 0,  0,    0,    0, 1, '{1, 0,    0}},
        '{0,      0,    1, 0,  4095, 0,    1, 1, '{1, 0,    0}},
        // current channel picked, voltage at full scale ignored
        '{0,      0,    0, 0,  4095, 0,    0, 1, '{1, 0,    0}},
        // widest offset: one count under the upper threshold, then on it
        '{0,      4095, 0, 0,  0,    4094, 0, 1, '{0, 0,    0}},
        '{0,      4095, 0, 0,  0,    4095, 0, 1, '{1, 0,    0}},
        '{0,      4095, 0, 0,  4095, 0,    1, 1, '{1, 0,    0}},
        '{0,      4095, 1, 0,  0,    4095, 1, 1, '{1, 0,    0}},
        '{0,      4095, 1, 0,  4095, 0,    0, 1, '{1, 0,    0}},
        // unit gain: midpoint lands on the sample, both directions
        '{65536,  0,    1, 0,  4095, 0,    0, 1, '{1, 4095, 0}},
        '{65536,  0,    1, 0,  0,    4095, 0, 1, '{1, 0,    0}},
        // no deviation, so no growth even with accumulation on
        '{65536,  0,    1, 1,  2048, 0,    1, 1, '{1, 2048, 0}},
        // zero gain holds the midpoint; hysteresis picks up the full gap
        '{0,      0,    1, 1,  4095, 0,    0, 1, '{1, 2048, 2047}},
        '{0,      0,    1, 1,  0,    0,    1, 0, '{0, 0,    0}},
        '{0,      0,    1, 1,  4095, 4095, 0, 0, '{0, 0,    0}},
        // accumulation off: hysteresis held but still reported
        '{0,      0,    1, 0,  0,    4095, 1, 0, '{0, 0,    0}},
        // half gain, rounding of negative steps
        '{32768,  0,    1, 0,  0,    0,    0, 0, '{0, 0,    0}},
        '{32768,  0,    1, 0,  1,    0,    0, 0, '{0, 0,    0}},
        '{1,      0,    1, 0,  4095, 0,    0, 0, '{0, 0,    0}},
        // gain near two: overshoot, then positive saturation
        '{131071, 0,    1, 1,  4095, 0,    0, 0, '{0, 0,    0}},
        '{131071, 0,    1, 1,  0,    0,    1, 0, '{0, 0,    0}},
        '{131071, 0,    1, 1,  4095, 0,    0, 0, '{0, 0,    0}},
        '{131071, 0,    1, 1,  0,    4095, 1, 0, '{0, 0,    0}},
        '{98304,  2048, 0, 1,  4095, 1234, 0, 0, '{0, 0,    0}},
        '{98304,  2048, 0, 1,  0,    2900, 1, 0, '{0, 0,    0}}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // voltage_sample, current_sample, level_before, zero pad
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // level_now, midpoint_out, adaptive_hys_out, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    // tracker copy of the slicer: registers and state
    cfg_t   cur_cfg = '{filter_gain: '0, hysteresis_offset: '0,
                        use_voltage: 1'b1, accumulate_enable: 1'b0};
    longint mid_track = 0;
    longint hys_track = 0;
    logic   last_level = 1'b0;

    slice_t slice_due_q [$];   // results owed by the slicer, oldest first

    bit idle_on = 1'b1;        // random gaps on both sides
    bit hold_req = 1'b0;       // ask the sink for one long back-pressure burst
    int fail_count = 0;
    int stall_cycles = 0;

    adaptive_hysteresis_slicer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    // Advance the tracker by one sample and return the result it owes.
    // Midpoint step is floor((diff * gain + half) / 2^16), clamped to 14 bits.
    function automatic slice_t slice_track(input logic [ADC_W-1:0] volt,
                                           input logic [ADC_W-1:0] curr,
                                           input logic lvl_before);
        slice_t r;
        longint x;
        longint gain;
        longint off;
        longint nm;
        longint thr;
        longint dev;
        longint nh;
        x    = longint'(cur_cfg.use_voltage ? volt : curr);
        gain = longint'(cur_cfg.filter_gain);
        off  = longint'(cur_cfg.hysteresis_offset);
        nm   = mid_track + (((x - mid_track) * gain + ROUND_HALF) >>> FRAC_W);
        if (nm < MID_MIN)
            nm = MID_MIN;
        if (nm > MID_MAX)
            nm = MID_MAX;
        mid_track = nm;
        // previous level low: upper threshold, high: lower threshold
        thr = lvl_before ? nm - off : nm + off;
        if (cur_cfg.accumulate_enable)
        begin
            dev = nm - x;
            if (dev < 0)
                dev = -dev;
            // grow only while the deviation beats hys/32; decay by hys/16
            if (dev > (hys_track >> HYS_GATE_SHIFT))
            begin
                nh = hys_track + dev - (hys_track >> HYS_DECAY_SHIFT);
                if (nh < 0)
                    nh = 0;
                if (nh > HYS_TOP)
                    nh = HYS_TOP;
                hys_track = nh;
            end
        end
        r.level_now    = (x < thr) ? 1'b0 : 1'b1;
        r.midpoint     = nm[MID_W-1:0];
        r.adaptive_hys = hys_track[HYS_W-1:0];
        return r;
    endfunction

    // Sample for the random part: rails, full range, or close to a threshold
    // so that the hysteresis actually decides the level.
    function automatic logic [ADC_W-1:0] pick_sample();
        longint near;
        int     off;
        off = int'(cur_cfg.hysteresis_offset);
        case ($urandom_range(7))
            0: return '0;
            1: return ADC_W'(ADC_MAX);
            2, 3:
            begin
                near = mid_track + int'($urandom_range(2 * off + 16)) - off - 8;
                if (near < 0)
                    return '0;
                if (near > ADC_MAX)
                    return ADC_W'(ADC_MAX);
                return near[ADC_W-1:0];
            end
            default: return ADC_W'($urandom_range(ADC_MAX));
        endcase
    endfunction

    // The stimulus tasks below run from just after a falling edge and return on one.

    task automatic offer_sample(input logic [ADC_W-1:0] volt, input logic [ADC_W-1:0] curr,
                                input logic lvl_before, input logic typed,
                                input slice_t typed_res);
        slice_t r;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({lvl_before, curr, volt});
        do
            @(posedge clk);
        while (!s_tready);
        // beat taken at this edge: settle what it owes
        r = slice_track(volt, curr, lvl_before);
        last_level = r.level_now;
        slice_due_q.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (slice_due_q.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // registers only change with the pipe empty
    task automatic load_config(input cfg_t c);
        drain_results();
        write_reg(REG_FILTER_GAIN, c.filter_gain);
        write_reg(REG_HYS_OFFSET,  CFG_DATA_W'(c.hysteresis_offset));
        write_reg(REG_USE_VOLTAGE, CFG_DATA_W'(c.use_voltage));
        write_reg(REG_ACC_ENABLE,  CFG_DATA_W'(c.accumulate_enable));
        cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic note_mismatch(input string field, input string want, input string got);
        fail_count++;
        $error("%s: expected %s, got %s", field, want, got);
    endtask

    // Result sink: random gaps, plus one long hold-off on request so that
    // the slicer backs up and drops s_tready.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Result check, field by field against the oldest owed result
    always @(posedge clk)
    begin : result_check
        slice_t got;
        slice_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.level_now    = m_tdata[0];
            got.midpoint     = m_tdata[MID_W:1];
            got.adaptive_hys = m_tdata[MID_W+HYS_W:MID_W+1];
            if (slice_due_q.size() == 0)
                note_mismatch("result beat", "none", $sformatf("%h", m_tdata));
            else
            begin
                want = slice_due_q.pop_front();
                if (got.level_now !== want.level_now)
                    note_mismatch("level_now", $sformatf("%0d", want.level_now),
                                  $sformatf("%0d", got.level_now));
                if (got.midpoint !== want.midpoint)
                    note_mismatch("midpoint_out", $sformatf("%0d", $signed(want.midpoint)),
                                  $sformatf("%0d", $signed(got.midpoint)));
                if (got.adaptive_hys !== want.adaptive_hys)
                    note_mismatch("adaptive_hys_out", $sformatf("%0d", want.adaptive_hys),
                                  $sformatf("%0d", got.adaptive_hys));
            end
        end
    end

    // Watchdog: too long with no beat moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t         row;
        cfg_t             want_cfg;
        logic [ADC_W-1:0] volt;
        logic [ADC_W-1:0] curr;
        logic             lb;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table; registers rewritten whenever a row changes them
        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            want_cfg.filter_gain       = row.gain;
            want_cfg.hysteresis_offset = row.offs;
            want_cfg.use_voltage       = row.use_v;
            want_cfg.accumulate_enable = row.acc_en;
            if (i == 0 || want_cfg != cur_cfg)
                load_config(want_cfg);
            offer_sample(row.volt, row.curr, row.lvl_before, row.typed, row.res);
        end

        // random phases: rails of the gain and offset first, then random ones
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: want_cfg.filter_gain = '0;
                1: want_cfg.filter_gain = GAIN_W'(GAIN_ONE);
                2: want_cfg.filter_gain = GAIN_W'(GAIN_TOP);
                3: want_cfg.filter_gain = GAIN_W'(1);
                default:
                    want_cfg.filter_gain = ($urandom_range(3) == 0) ?
                        GAIN_W'($urandom_range(GAIN_TOP)) :
                        GAIN_W'($urandom_range(GAIN_ONE));
            endcase
            if (p == 0)
                want_cfg.hysteresis_offset = OFFS_W'(OFFS_TOP);
            else if (p == 1)
                want_cfg.hysteresis_offset = '0;
            else
                want_cfg.hysteresis_offset = $urandom_range(1) ?
                    OFFS_W'($urandom_range(OFFS_TOP)) : OFFS_W'($urandom_range(256));
            want_cfg.use_voltage       = p[0];
            want_cfg.accumulate_enable = (p % 3) != 2;
            load_config(want_cfg);
            // one phase runs flat out on both sides
            idle_on = (p != 3);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (p == 5 && n == 40)
                    hold_req = 1'b1;
                // sender backs off until everything owed is in
                if (p == 5 && n == 150)
                    drain_results();
                volt = pick_sample();
                curr = pick_sample();
                // mostly feed the decided level back, as a real slicer would
                lb = ($urandom_range(3) == 0) ? 1'($urandom_range(1)) : last_level;
                offer_sample(volt, curr, lb, 1'b0, '0);
            end
        end

        drain_results();
        // room for any stray result beat after the drain
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
